[rtl/tfcf_pkg.sv]
// Shared types, constants and check functions for the transcript field checker and framer.
`default_nettype none
package tfcf_pkg;

  // Field numbering and limits.
  localparam logic [3:0] EXPIRY_FIELD = 4'd12;
  localparam logic [6:0] SITE_MAX     = 7'd64;
  localparam logic [6:0] EXPIRY_LEN   = 7'd8;
  localparam logic [6:0] POS_MAX      = 7'd127;
  localparam int unsigned TAG_LEN     = 28;
  localparam int unsigned TAG_W       = $clog2(TAG_LEN);
  localparam logic [TAG_W-1:0] TAG_LAST = TAG_W'(TAG_LEN - 1);

  // Queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Error codes.
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_ORDER   = 3'd1;
  localparam logic [2:0] ERR_LENGTH  = 3'd2;
  localparam logic [2:0] ERR_CHAR    = 3'd3;
  localparam logic [2:0] ERR_UUID    = 3'd4;
  localparam logic [2:0] ERR_EXPIRY  = 3'd5;

  // One queue entry: what the back part emits for one accepted input word.
  typedef struct packed {
    logic       tag;       // domain tag first
    logic       prefix;    // two-byte length prefix
    logic [6:0] flen;      // low prefix byte
    logic       emit;      // one content or status byte
    logic [7:0] data;
    logic       final_w;   // closing word of the transcript
    logic [2:0] err;       // first error, valid with final_w
  } tfcf_entry_t;

  // Keep the earliest error.
  function automatic logic [2:0] merge_err(input logic [2:0] cur, input logic [2:0] nxt);
    merge_err = (cur != ERR_NONE) ? cur : nxt;
  endfunction

  function automatic logic is_uuid_field(input logic [3:0] f);
    is_uuid_field = (f == 4'd0) || (f == 4'd3) || (f == 4'd4) || (f == 4'd6);
  endfunction

  function automatic logic is_hex_lower(input logic [7:0] b);
    is_hex_lower = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66);
  endfunction

  // Declared length rule per field.
  function automatic logic length_ok(input logic [3:0] f, input logic [6:0] len);
    logic r;
    r = 1'b1;
    if (is_uuid_field(f)) begin
      r = (len == 7'd36);
    end else begin
      unique case (f)
        4'd1, 4'd2, 4'd8, 4'd11: r = (len == 7'd32);
        4'd5:    r = (len == 7'd43);
        4'd7:    r = (len == 7'd71);
        4'd9:    r = (len <= SITE_MAX);
        4'd10:   r = (len == 7'd0) || (len == 7'd71);
        default: r = 1'b1;
      endcase
    end
    length_ok = r;
  endfunction

  // Digest head "sha256:" by position.
  function automatic logic [7:0] digest_head(input logic [2:0] p);
    logic [7:0] r;
    unique case (p)
      3'd0:    r = 8'h73;
      3'd1:    r = 8'h68;
      3'd2:    r = 8'h61;
      3'd3:    r = 8'h32;
      3'd4:    r = 8'h35;
      3'd5:    r = 8'h36;
      3'd6:    r = 8'h3a;
      default: r = 8'h00;
    endcase
    digest_head = r;
  endfunction

  // Character rule of byte b at position p of field f.
  function automatic logic [2:0] byte_check(input logic [3:0] f, input logic [6:0] p,
                                            input logic [7:0] b);
    logic [2:0] r;
    logic       good;
    r    = ERR_NONE;
    good = 1'b1;
    if (is_uuid_field(f)) begin
      if (p == 7'd8 || p == 7'd13 || p == 7'd18 || p == 7'd23) begin
        r = (b == 8'h2d) ? ERR_NONE : ERR_CHAR;
      end else if (p == 7'd14 && b != 8'h34) begin
        r = ERR_UUID;
      end else if (p == 7'd19 && b != 8'h38 && b != 8'h39 && b != 8'h61 && b != 8'h62) begin
        r = ERR_UUID;
      end else begin
        r = is_hex_lower(b) ? ERR_NONE : ERR_CHAR;
      end
    end else if (f == 4'd5) begin
      good = (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) ||
             (b >= 8'h30 && b <= 8'h39) || b == 8'h2d || b == 8'h5f;
      r = good ? ERR_NONE : ERR_CHAR;
    end else if (f == 4'd7 || f == 4'd10) begin
      if (p < 7'd7) begin
        r = (b == digest_head(p[2:0])) ? ERR_NONE : ERR_CHAR;
      end else begin
        r = is_hex_lower(b) ? ERR_NONE : ERR_CHAR;
      end
    end else if (f == 4'd9) begin
      r = (b >= 8'h21 && b <= 8'h7e) ? ERR_NONE : ERR_CHAR;
    end
    byte_check = r;
  endfunction

  // Fixed domain tag, one byte per index.
  function automatic logic [7:0] tag_byte(input logic [TAG_W-1:0] i);
    logic [7:0] r;
    unique case (i)
      5'd0:  r = 8'h64;  5'd1:  r = 8'h72;  5'd2:  r = 8'h65;  5'd3:  r = 8'h61;
      5'd4:  r = 8'h6d;  5'd5:  r = 8'h69;  5'd6:  r = 8'h6e;  5'd7:  r = 8'h67;
      5'd8:  r = 8'h77;  5'd9:  r = 8'h72;  5'd10: r = 8'h74;  5'd11: r = 8'h2d;
      5'd12: r = 8'h61;  5'd13: r = 8'h70;  5'd14: r = 8'h2d;  5'd15: r = 8'h65;
      5'd16: r = 8'h6e;  5'd17: r = 8'h72;  5'd18: r = 8'h6f;  5'd19: r = 8'h6c;
      5'd20: r = 8'h6c;  5'd21: r = 8'h6d;  5'd22: r = 8'h65;  5'd23: r = 8'h6e;
      5'd24: r = 8'h74;  5'd25: r = 8'h2d;  5'd26: r = 8'h76;  5'd27: r = 8'h31;
      default: r = 8'h00;
    endcase
    tag_byte = r;
  endfunction

endpackage
`default_nettype wire

[rtl/tfcf_front.sv]
// Front part: accepts input words, tracks the field sequence and checks every byte.
`default_nettype none
module tfcf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [3:0]           field_index_i,
  input  logic [6:0]           field_length_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 has_byte_i,
  input  logic                 last_in_field_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output tfcf_pkg::tfcf_entry_t entry_o
);
  import tfcf_pkg::*;

  logic [3:0] exp_field_q, exp_field_d;
  logic [6:0] pos_q, pos_d;
  logic [6:0] decl_q, decl_d;
  logic [2:0] err_q, err_d;
  logic       exp_nz_q, exp_nz_d;
  logic       open_q, open_d;

  logic       accept, active, opening, is_expiry;
  logic [6:0] decl_cur, pos_cur, pos_nx;
  logic       exp_nz;
  logic [2:0] err;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign active     = has_byte_i || last_in_field_i;
  assign opening    = !open_q;
  assign is_expiry  = (exp_field_q >= EXPIRY_FIELD);

  // Checks in stream order; the first error found is kept.
  always_comb begin
    err      = err_q;
    decl_cur = opening ? (is_expiry ? EXPIRY_LEN : field_length_i) : decl_q;
    pos_cur  = opening ? 7'd0 : pos_q;
    if (field_index_i != exp_field_q) begin
      err = merge_err(err, ERR_ORDER);
    end
    if (opening && !is_expiry && !length_ok(exp_field_q, field_length_i)) begin
      err = merge_err(err, ERR_LENGTH);
    end
    if (has_byte_i) begin
      if (pos_cur >= decl_cur) begin
        err = merge_err(err, ERR_LENGTH);
      end else begin
        err = merge_err(err, byte_check(exp_field_q, pos_cur, data_byte_i));
      end
    end
    pos_nx = (has_byte_i && pos_cur != POS_MAX) ? pos_cur + 7'd1 : pos_cur;
    exp_nz = exp_nz_q || (is_expiry && has_byte_i && data_byte_i != 8'h00);
    if (last_in_field_i) begin
      if (pos_nx != decl_cur) begin
        err = merge_err(err, ERR_LENGTH);
      end
      if (is_expiry) begin
        if (!has_byte_i) begin
          err = merge_err(err, ERR_LENGTH);
        end
        if (!exp_nz) begin
          err = merge_err(err, ERR_EXPIRY);
        end
      end
    end
  end

  // Queue entry for the back part.
  always_comb begin
    entry_o.tag     = opening && (exp_field_q == 4'd0);
    entry_o.prefix  = opening && !is_expiry;
    entry_o.flen    = field_length_i;
    entry_o.emit    = has_byte_i || (last_in_field_i && is_expiry);
    entry_o.data    = has_byte_i ? data_byte_i : 8'h00;
    entry_o.final_w = last_in_field_i && is_expiry;
    entry_o.err     = err;
  end

  // A word with no byte that does not close its field produces nothing.
  assign push_o = accept && active && (entry_o.prefix || entry_o.emit || entry_o.tag);

  // Field sequence state.
  always_comb begin
    exp_field_d = exp_field_q;
    pos_d       = pos_q;
    decl_d      = decl_q;
    err_d       = err_q;
    exp_nz_d    = exp_nz_q;
    open_d      = open_q;
    if (accept && active) begin
      if (last_in_field_i && is_expiry) begin
        exp_field_d = 4'd0;
        pos_d       = 7'd0;
        decl_d      = 7'd0;
        err_d       = ERR_NONE;
        exp_nz_d    = 1'b0;
        open_d      = 1'b0;
      end else if (last_in_field_i) begin
        exp_field_d = exp_field_q + 4'd1;
        pos_d       = 7'd0;
        decl_d      = decl_cur;
        err_d       = err;
        exp_nz_d    = exp_nz;
        open_d      = 1'b0;
      end else begin
        pos_d    = pos_nx;
        decl_d   = decl_cur;
        err_d    = err;
        exp_nz_d = exp_nz;
        open_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_field_q <= 4'd0;
      pos_q       <= 7'd0;
      decl_q      <= 7'd0;
      err_q       <= ERR_NONE;
      exp_nz_q    <= 1'b0;
      open_q      <= 1'b0;
    end else begin
      exp_field_q <= exp_field_d;
      pos_q       <= pos_d;
      decl_q      <= decl_d;
      err_q       <= err_d;
      exp_nz_q    <= exp_nz_d;
      open_q      <= open_d;
    end
  end

endmodule
`default_nettype wire

[rtl/tfcf_queue.sv]
// Short queue of emit entries between the front and back parts.
`default_nettype none
module tfcf_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tfcf_pkg::tfcf_entry_t push_entry_i,
  input  logic                  pop_i,
  output tfcf_pkg::tfcf_entry_t head_o,
  output logic                  empty_o,
  output logic                  full_o
);
  import tfcf_pkg::*;

  tfcf_entry_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

[rtl/tfcf_back.sv]
// Back part: expands queue entries into output bytes through a registered output word.
`default_nettype none
module tfcf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tfcf_pkg::tfcf_entry_t head_i,
  input  logic                  head_valid_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  last_out_o,
  output logic                  ok_o,
  output logic [2:0]            error_code_o
);
  import tfcf_pkg::*;

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_TAG   = 3'd1;
  localparam logic [2:0] PH_HI    = 3'd2;
  localparam logic [2:0] PH_LO    = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;

  logic [2:0]       phase_q, phase_d, phase_eff;
  logic [TAG_W-1:0] tcnt_q, tcnt_d;
  logic             can_load, fire;
  logic             valid_q, valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, ok_q;
  logic [2:0]       err_q;
  logic [7:0]       next_byte;
  logic             next_final;

  assign can_load = !valid_q || out_ready_i;
  assign fire     = head_valid_i && can_load;

  // Step within the head entry, and the byte it yields.
  always_comb begin
    if (phase_q != PH_START) begin
      phase_eff = phase_q;
    end else if (head_i.tag) begin
      phase_eff = PH_TAG;
    end else if (head_i.prefix) begin
      phase_eff = PH_HI;
    end else begin
      phase_eff = PH_DATA;
    end
    phase_d    = phase_q;
    tcnt_d     = tcnt_q;
    pop_o      = 1'b0;
    next_byte  = 8'h00;
    next_final = 1'b0;
    unique case (phase_eff)
      PH_TAG: begin
        next_byte = tag_byte(tcnt_q);
        if (fire) begin
          tcnt_d  = (tcnt_q == TAG_LAST) ? '0 : tcnt_q + 1'b1;
          phase_d = (tcnt_q == TAG_LAST) ? PH_HI : PH_TAG;
        end
      end
      PH_HI: begin
        next_byte = 8'h00;
        if (fire) begin
          phase_d = PH_LO;
        end
      end
      PH_LO: begin
        next_byte = {1'b0, head_i.flen};
        if (fire) begin
          phase_d = head_i.emit ? PH_DATA : PH_START;
          pop_o   = !head_i.emit;
        end
      end
      PH_DATA: begin
        next_byte  = head_i.data;
        next_final = head_i.final_w;
        if (fire) begin
          phase_d = PH_START;
          pop_o   = 1'b1;
        end
      end
      default: begin
        next_byte = 8'h00;
      end
    endcase
  end

  // Output word register.
  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (fire) begin
      valid_d = 1'b1;
      byte_d  = next_byte;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      tcnt_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      tcnt_q  <= tcnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (fire) begin
      last_q <= next_final;
      ok_q   <= next_final && (head_i.err == ERR_NONE);
      err_q  <= next_final ? head_i.err : ERR_NONE;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign last_out_o   = last_q;
  assign ok_o         = ok_q;
  assign error_code_o = err_q;

endmodule
`default_nettype wire

[rtl/transcript_field_checker_framer_core.sv]
// Top level of the transcript field checker and framer.
//
// Takes one input word per cycle and emits the framed transcript one byte per cycle on the
// master stream. Outside the expiry field, a field's opening word produces three bytes (prefix
// and first content byte), the first word of a transcript thirty-one (28-byte domain tag,
// prefix, content byte), and every other word one byte, or none for an empty word; the byte
// rate is set by the output sequencer, which emits one byte per cycle while m_tready is high
// and the queue is not empty. A four-entry queue lets input words keep arriving during those
// bursts; input stalls only when it is full. The last byte of a transcript carries tlast, ok
// and the first error code; those status bits are zero on every other byte.
`default_nettype none
module transcript_field_checker_framer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [6:0] field_length, [14:7] data_byte, [15] zero
  input  logic [4:0]  s_tuser,   // [3:0] field_index, [4] has_byte
  input  logic        s_tlast,   // last_in_field
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] ok, [11:9] error_code, [15:12] zero
  output logic        m_tlast    // last_out
);
  import tfcf_pkg::*;

  tfcf_entry_t push_entry, head;
  logic        push, pop, q_empty, q_full;
  logic [7:0]  out_byte;
  logic        ok;
  logic [2:0]  error_code;

  tfcf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_tvalid),
    .in_ready_o      (s_tready),
    .field_index_i   (s_tuser[3:0]),
    .field_length_i  (s_tdata[6:0]),
    .data_byte_i     (s_tdata[14:7]),
    .has_byte_i      (s_tuser[4]),
    .last_in_field_i (s_tlast),
    .q_full_i        (q_full),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  tfcf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (q_empty),
    .full_o       (q_full)
  );

  tfcf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!q_empty),
    .pop_o        (pop),
    .out_valid_o  (m_tvalid),
    .out_ready_i  (m_tready),
    .out_byte_o   (out_byte),
    .last_out_o   (m_tlast),
    .ok_o         (ok),
    .error_code_o (error_code)
  );

  assign m_tdata = {4'b0000, error_code, ok, out_byte};

endmodule
`default_nettype wire

[rtl/tfcf_checker.sv]
// Port-level checker for the transcript field checker and framer, bound to the top level.
`default_nettype none
module tfcf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [4:0]  s_tuser,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        m_tlast
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // Status bits are zero on every byte but the last one of a transcript.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tlast |-> m_tdata[11:8] == 4'd0)
    else $error("status bits set on a non-final byte");

  // On the final byte, ok agrees with the error code.
  a_ok_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tlast |-> m_tdata[8] == (m_tdata[11:9] == 3'd0))
    else $error("ok and error code disagree");

  // Only defined error codes appear, and padding stays zero.
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[11:9] != 3'd6 && m_tdata[11:9] != 3'd7 && m_tdata[15:12] == 4'd0)
    else $error("undefined error code or padding set");

endmodule

bind transcript_field_checker_framer_core tfcf_checker u_tfcf_checker (.*);
`default_nettype wire
